FILE: design/quaternion_slerp_core_assert.svh
// assertion macros shared by the slerp core
`ifndef QUATERNION_SLERP_CORE_ASSERT_SVH
`define QUATERNION_SLERP_CORE_ASSERT_SVH

// checked only while out of reset
`define QSLERP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked during reset too
`define QSLERP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/qslerp_pkg.sv
// types, constants and tables of the quaternion slerp core
`timescale 1ns / 1ps
package qslerp_pkg;

  localparam int COMPONENT_FRAC_BITS = 14;
  localparam int BLEND_FRAC_BITS     = 16;
  localparam int UNIT_BITS           = 30;

  localparam int COMP_W      = 16;
  localparam int BLEND_W     = 17;
  localparam int DOT_W       = 34;
  localparam int D30_W       = 32;
  localparam int MAG_W       = 31;
  localparam int RAD_W       = 61;
  localparam int ISQRT_STEPS = 31;
  localparam int ANG_STEPS   = 17;
  localparam int VEC_W       = 34;
  localparam int ANG_W       = 20;
  localparam int THETA_W     = 18;
  localparam int SIN_W       = 33;
  localparam int NUM_W       = 50;
  localparam int REM_W       = 46;
  localparam int QUOT_BITS   = 16;

  localparam logic signed [DOT_W-1:0] ONE2 =
    DOT_W'(longint'(1) << (2 * COMPONENT_FRAC_BITS));
  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << BLEND_FRAC_BITS;
  localparam logic [2*MAG_W-1:0] RAD_TOP = (2*MAG_W)'(1) << (2 * UNIT_BITS);

  localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  localparam logic signed [SIN_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16  = 20'sd102944;
  localparam logic signed [ANG_W-1:0] PI_Q16       = 20'sd205887;

  localparam logic signed [ANG_W-1:0] ATAN_Q16 [ANG_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1
  };

  typedef logic [3:0][COMP_W-1:0] quat_t;

  typedef struct packed {
    quat_t              f;
    quat_t              g;
    logic [BLEND_W-1:0] t;
    logic               same;
    logic               one;
    quat_t              lerp;
    logic               lerp_sat;
  } side_t;

  typedef struct packed {
    side_t                    side;
    logic signed [D30_W-1:0]  d30;
  } mid_t;

  typedef struct packed {
    side_t              side;
    logic [MAG_W-1:0]   s;
  } post_t;

  typedef struct packed {
    logic                 neg;
    logic                 zero;
    logic                 sat;
    logic [QUOT_BITS-1:0] q;
  } lane_t;

endpackage

FILE: design/qslerp_in_if.sv
// input channel of the slerp core
`timescale 1ns / 1ps
interface qslerp_in_if;
  import qslerp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COMP_W-1:0]  from_w;
  logic signed [COMP_W-1:0]  from_x;
  logic signed [COMP_W-1:0]  from_y;
  logic signed [COMP_W-1:0]  from_z;
  logic signed [COMP_W-1:0]  to_w;
  logic signed [COMP_W-1:0]  to_x;
  logic signed [COMP_W-1:0]  to_y;
  logic signed [COMP_W-1:0]  to_z;
  logic [BLEND_W-1:0]        blend;
  modport source (output valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z,
                  blend, input ready);
  modport sink (input valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z,
                blend, output ready);
endinterface

FILE: design/qslerp_out_if.sv
// output channel of the slerp core
`timescale 1ns / 1ps
interface qslerp_out_if;
  import qslerp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COMP_W-1:0]  out_w;
  logic signed [COMP_W-1:0]  out_x;
  logic signed [COMP_W-1:0]  out_y;
  logic signed [COMP_W-1:0]  out_z;
  logic                      saturated;
  modport source (output valid, out_w, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_w, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: design/quaternion_slerp_core.sv
// Quaternion slerp core: a 94-stage pipeline, one interpolation per clock when
// the output does not stall. Each beat carries two Q2.14 quaternions and a Q1.16
// blend factor (above 1.0 is taken as 1.0) and gives one result beat; a new beat
// is taken every cycle while the output does not stall. The depth is set by the
// integer square root for sin(theta) (31 stages, one root bit each), the cordic
// vectoring for theta (19), the two cordic sine lanes with the angle split (20),
// the numerator and 16-bit restoring division (19), the front dot product (4)
// and the output register. When the output register holds a beat that is not
// taken, the whole pipeline holds and ready drops; nothing is lost or repeated.
// Equal inputs return the first quaternion; a dot of one or more falls back to
// a component-wise lerp; saturated flags a zero sine or any clipped component.
`timescale 1ns / 1ps
`include "quaternion_slerp_core_assert.svh"
module quaternion_slerp_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  qslerp_in_if.sink    in_i,
  qslerp_out_if.source out_o
);
  import qslerp_pkg::*;

  logic en;

  quat_t from_quat, to_quat;

  logic                    fr_vld;
  mid_t                    fr_mid;
  logic [RAD_W-1:0]        fr_rad;
  logic                    sq_vld;
  mid_t                    sq_mid;
  logic [MAG_W-1:0]        sq_root;
  logic                    at_vld;
  post_t                   at_post;
  logic [THETA_W-1:0]      at_theta;
  logic                    sn_vld;
  post_t                   sn_post;
  logic signed [SIN_W-1:0] sn_w_from, sn_w_to;
  logic                    div_vld;
  post_t                   div_post;
  lane_t [3:0]             div_lane;

  quat_t quo;
  logic  quo_sat;

  logic  out_vld_q;
  quat_t out_q, out_d;
  logic  sat_q, sat_d;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign from_quat = {in_i.from_z, in_i.from_y, in_i.from_x, in_i.from_w};
  assign to_quat   = {in_i.to_z, in_i.to_y, in_i.to_x, in_i.to_w};

  qslerp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_i.valid),
    .from_i  (from_quat),
    .to_i    (to_quat),
    .blend_i (in_i.blend),
    .vld_o   (fr_vld),
    .mid_o   (fr_mid),
    .rad_o   (fr_rad)
  );

  qslerp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .mid_i  (fr_mid),
    .rad_i  (fr_rad),
    .vld_o  (sq_vld),
    .mid_o  (sq_mid),
    .root_o (sq_root)
  );

  qslerp_atan u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sq_vld),
    .mid_i   (sq_mid),
    .root_i  (sq_root),
    .vld_o   (at_vld),
    .post_o  (at_post),
    .theta_o (at_theta)
  );

  qslerp_sine u_sine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (at_vld),
    .post_i   (at_post),
    .theta_i  (at_theta),
    .vld_o    (sn_vld),
    .post_o   (sn_post),
    .w_from_o (sn_w_from),
    .w_to_o   (sn_w_to)
  );

  qslerp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (sn_vld),
    .post_i   (sn_post),
    .w_from_i (sn_w_from),
    .w_to_i   (sn_w_to),
    .vld_o    (div_vld),
    .post_o   (div_post),
    .lane_o   (div_lane)
  );

  // final pick: equal inputs, then lerp fallback, then slerp quotient
  always_comb begin
    quo_sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (div_post.s == '0) begin
        quo_sat = 1'b1;
        quo[i]  = div_lane[i].zero ? '0 : (div_lane[i].neg ? COMP_MIN : COMP_MAX);
      end else if (div_lane[i].sat) begin
        quo_sat = 1'b1;
        quo[i]  = div_lane[i].neg ? COMP_MIN : COMP_MAX;
      end else if (div_lane[i].neg) begin
        quo[i] = COMP_W'(-$signed({1'b0, div_lane[i].q}));
      end else begin
        quo[i] = div_lane[i].q;
      end
    end
    priority if (div_post.side.same) begin
      out_d = div_post.side.f;
      sat_d = 1'b0;
    end else if (div_post.side.one) begin
      out_d = div_post.side.lerp;
      sat_d = div_post.side.lerp_sat;
    end else begin
      out_d = quo;
      sat_d = quo_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= div_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_w     = out_q[0];
  assign out_o.out_x     = out_q[1];
  assign out_o.out_y     = out_q[2];
  assign out_o.out_z     = out_q[3];
  assign out_o.saturated = sat_q;

  `QSLERP_ASSERT(a_sat_code, out_vld_q && sat_q |->
    (out_q[0] == COMP_MAX) || (out_q[0] == COMP_MIN) ||
    (out_q[1] == COMP_MAX) || (out_q[1] == COMP_MIN) ||
    (out_q[2] == COMP_MAX) || (out_q[2] == COMP_MIN) ||
    (out_q[3] == COMP_MAX) || (out_q[3] == COMP_MIN) || (out_q == '0),
    "saturated beat without a clipped component")
  `QSLERP_ASSERT(a_stall_hold, !en |=> $stable(div_vld) && $stable(out_vld_q), "pipeline moved during a stall")
  `QSLERP_ASSERT(a_pipe_fill, div_vld && en |=> out_vld_q, "finished beat dropped before the output register")
  `QSLERP_ASSERT_RST(a_rst_empty, !rst_ni |=> !out_vld_q, "output valid right after reset")

endmodule

FILE: design/qslerp_front.sv
// front stages: products, dot, clamp, lerp fallback, radicand 1 - dot^2
`timescale 1ns / 1ps
module qslerp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  qslerp_pkg::quat_t             from_i,
  input  qslerp_pkg::quat_t             to_i,
  input  logic [qslerp_pkg::BLEND_W-1:0] blend_i,
  output logic                          vld_o,
  output qslerp_pkg::mid_t              mid_o,
  output logic [qslerp_pkg::RAD_W-1:0]  rad_o
);
  import qslerp_pkg::*;

  localparam int DOT_SHIFT = 2 * COMPONENT_FRAC_BITS - UNIT_BITS;
  localparam int DOT_SHL   = (DOT_SHIFT < 0) ? -DOT_SHIFT : 0;
  localparam int DOT_SHR   = (DOT_SHIFT > 0) ? DOT_SHIFT : 0;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int LP_W      = COMP_W + BLEND_W + 2;
  localparam int LS_W      = COMP_W + 4;

  // stage 1
  logic                     vld1_q;
  quat_t                    f1_q, g1_q;
  logic [BLEND_W-1:0]       t1_q, t1_d;
  logic                     same1_q, same1_d;
  logic signed [PROD_W-1:0] p1_q [4];
  logic signed [PROD_W-1:0] p1_d [4];
  logic signed [LP_W-1:0]   lp1_q [4];
  logic signed [LP_W-1:0]   lp1_d [4];

  always_comb begin
    t1_d    = (blend_i > BLEND_ONE) ? BLEND_ONE : blend_i;
    same1_d = (from_i == to_i);
    for (int i = 0; i < 4; i++) begin
      p1_d[i]  = PROD_W'($signed(from_i[i])) * PROD_W'($signed(to_i[i]));
      lp1_d[i] = (LP_W'($signed(to_i[i])) - LP_W'($signed(from_i[i])))
                 * LP_W'($signed({1'b0, t1_d}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (en_i) vld1_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q    <= from_i;
      g1_q    <= to_i;
      t1_q    <= t1_d;
      same1_q <= same1_d;
      p1_q    <= p1_d;
      lp1_q   <= lp1_d;
    end
  end

  // stage 2
  logic                     vld2_q;
  mid_t                     mid2_q, mid2_d;
  logic [MAG_W-1:0]         m2_q, m2_d;
  logic signed [DOT_W-1:0]  dot, dotc;
  logic signed [LS_W-1:0]   ls;

  always_comb begin
    dot = DOT_W'(p1_q[0]) + DOT_W'(p1_q[1]) + DOT_W'(p1_q[2]) + DOT_W'(p1_q[3]);
    if (dot > ONE2) dotc = ONE2;
    else if (dot < -ONE2) dotc = -ONE2;
    else dotc = dot;
    mid2_d.side.f        = f1_q;
    mid2_d.side.g        = g1_q;
    mid2_d.side.t        = t1_q;
    mid2_d.side.same     = same1_q;
    mid2_d.side.one      = (dotc == ONE2);
    mid2_d.side.lerp_sat = 1'b0;
    mid2_d.d30           = D30_W'((dotc <<< DOT_SHL) >>> DOT_SHR);
    m2_d = MAG_W'((mid2_d.d30 < 0) ? -mid2_d.d30 : mid2_d.d30);
    for (int i = 0; i < 4; i++) begin
      ls = LS_W'($signed(f1_q[i])) + LS_W'(lp1_q[i] >>> BLEND_FRAC_BITS);
      if (ls > LS_W'(COMP_MAX)) begin
        mid2_d.side.lerp[i]  = COMP_MAX;
        mid2_d.side.lerp_sat = 1'b1;
      end else if (ls < LS_W'(COMP_MIN)) begin
        mid2_d.side.lerp[i]  = COMP_MIN;
        mid2_d.side.lerp_sat = 1'b1;
      end else begin
        mid2_d.side.lerp[i] = COMP_W'(ls);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld2_q <= 1'b0;
    else if (en_i) vld2_q <= vld1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid2_q <= mid2_d;
      m2_q   <= m2_d;
    end
  end

  // stage 3: square of |dot|
  logic                   vld3_q;
  mid_t                   mid3_q;
  logic [2*MAG_W-1:0]     msq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld3_q <= 1'b0;
    else if (en_i) vld3_q <= vld2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid3_q <= mid2_q;
      msq3_q <= (2*MAG_W)'(m2_q) * (2*MAG_W)'(m2_q);
    end
  end

  // stage 4: radicand
  logic               vld4_q;
  mid_t               mid4_q;
  logic [RAD_W-1:0]   rad4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld4_q <= 1'b0;
    else if (en_i) vld4_q <= vld3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid4_q <= mid3_q;
      rad4_q <= RAD_W'(RAD_TOP - msq3_q);
    end
  end

  assign vld_o = vld4_q;
  assign mid_o = mid4_q;
  assign rad_o = rad4_q;

endmodule

FILE: design/qslerp_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qslerp_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  qslerp_pkg::mid_t              mid_i,
  input  logic [qslerp_pkg::RAD_W-1:0]  rad_i,
  output logic                          vld_o,
  output qslerp_pkg::mid_t              mid_o,
  output logic [qslerp_pkg::MAG_W-1:0]  root_o
);
  import qslerp_pkg::*;

  localparam int ACC_W = RAD_W + 1;

  logic             vld_q [ISQRT_STEPS];
  mid_t             mid_q [ISQRT_STEPS];
  logic [RAD_W-1:0] v_q   [ISQRT_STEPS];
  logic [ACC_W-1:0] r_q   [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [ACC_W-1:0] STEP_BIT = ACC_W'(1) << (2 * (ISQRT_STEPS - 1 - k));
    logic             vld_in;
    mid_t             mid_in;
    logic [RAD_W-1:0] v_in, v_d;
    logic [ACC_W-1:0] r_in, r_d, trial;

    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign mid_in = mid_i;
      assign v_in   = rad_i;
      assign r_in   = '0;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign mid_in = mid_q[k-1];
      assign v_in   = v_q[k-1];
      assign r_in   = r_q[k-1];
    end

    always_comb begin
      trial = r_in + STEP_BIT;
      if (ACC_W'(v_in) >= trial) begin
        v_d = v_in - RAD_W'(trial);
        r_d = (r_in >> 1) + STEP_BIT;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mid_q[k] <= mid_in;
        v_q[k]   <= v_d;
        r_q[k]   <= r_d;
      end
    end
  end

  assign vld_o  = vld_q[ISQRT_STEPS-1];
  assign mid_o  = mid_q[ISQRT_STEPS-1];
  assign root_o = MAG_W'(r_q[ISQRT_STEPS-1]);

endmodule

FILE: design/qslerp_atan.sv
// angle theta = atan2(sin, dot) by pipelined cordic vectoring
`timescale 1ns / 1ps
module qslerp_atan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  qslerp_pkg::mid_t                mid_i,
  input  logic [qslerp_pkg::MAG_W-1:0]    root_i,
  output logic                            vld_o,
  output qslerp_pkg::post_t               post_o,
  output logic [qslerp_pkg::THETA_W-1:0]  theta_o
);
  import qslerp_pkg::*;

  logic                    vld_q  [ANG_STEPS+1];
  post_t                   post_q [ANG_STEPS+1];
  logic signed [VEC_W-1:0] x_q    [ANG_STEPS+1];
  logic signed [VEC_W-1:0] y_q    [ANG_STEPS+1];
  logic signed [ANG_W-1:0] z_q    [ANG_STEPS+1];

  // prep: a negative dot is turned a quarter so x stays non-negative
  logic signed [VEC_W-1:0] x0_d, y0_d;
  logic signed [ANG_W-1:0] z0_d;

  always_comb begin
    if (!mid_i.d30[D30_W-1]) begin
      x0_d = VEC_W'(mid_i.d30);
      y0_d = VEC_W'($signed({1'b0, root_i}));
      z0_d = '0;
    end else begin
      x0_d = VEC_W'($signed({1'b0, root_i}));
      y0_d = -VEC_W'(mid_i.d30);
      z0_d = HALF_PI_Q16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      post_q[0].side <= mid_i.side;
      post_q[0].s    <= root_i;
      x_q[0]         <= x0_d;
      y_q[0]         <= y0_d;
      z_q[0]         <= z0_d;
    end
  end

  for (genvar k = 0; k < ANG_STEPS; k++) begin : g_vec
    logic signed [VEC_W-1:0] x_d, y_d;
    logic signed [ANG_W-1:0] z_d;

    always_comb begin
      if (y_q[k] > 0) begin
        x_d = x_q[k] + (y_q[k] >>> k);
        y_d = y_q[k] - (x_q[k] >>> k);
        z_d = z_q[k] + ATAN_Q16[k];
      end else begin
        x_d = x_q[k] - (y_q[k] >>> k);
        y_d = y_q[k] + (x_q[k] >>> k);
        z_d = z_q[k] - ATAN_Q16[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        post_q[k+1] <= post_q[k];
        x_q[k+1]    <= x_d;
        y_q[k+1]    <= y_d;
        z_q[k+1]    <= z_d;
      end
    end
  end

  // clamp to [0, pi]
  logic                vldc_q;
  post_t               postc_q;
  logic [THETA_W-1:0]  thc_q, thc_d;

  always_comb begin
    if (z_q[ANG_STEPS] < 0) thc_d = '0;
    else if (z_q[ANG_STEPS] > PI_Q16) thc_d = THETA_W'(PI_Q16);
    else thc_d = THETA_W'(z_q[ANG_STEPS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vldc_q <= 1'b0;
    else if (en_i) vldc_q <= vld_q[ANG_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      postc_q <= post_q[ANG_STEPS];
      thc_q   <= thc_d;
    end
  end

  assign vld_o   = vldc_q;
  assign post_o  = postc_q;
  assign theta_o = thc_q;

endmodule

FILE: design/qslerp_sine.sv
// blend angles and their sines by two pipelined cordic rotation lanes
`timescale 1ns / 1ps
module qslerp_sine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  qslerp_pkg::post_t                    post_i,
  input  logic [qslerp_pkg::THETA_W-1:0]       theta_i,
  output logic                                 vld_o,
  output qslerp_pkg::post_t                    post_o,
  output logic signed [qslerp_pkg::SIN_W-1:0]  w_from_o,
  output logic signed [qslerp_pkg::SIN_W-1:0]  w_to_o
);
  import qslerp_pkg::*;

  localparam int PRD_W = THETA_W + BLEND_W;

  // stage a: theta * t
  logic                vlda_q;
  post_t               posta_q;
  logic [THETA_W-1:0]  tha_q;
  logic [PRD_W-1:0]    prda_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vlda_q <= 1'b0;
    else if (en_i) vlda_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      posta_q <= post_i;
      tha_q   <= theta_i;
      prda_q  <= PRD_W'(theta_i) * PRD_W'(post_i.side.t);
    end
  end

  // stage b: split theta into the two angles
  logic                vldb_q;
  post_t               postb_q;
  logic [THETA_W-1:0]  ato_b_q, afr_b_q, ato_b_d;

  assign ato_b_d = THETA_W'(prda_q >> BLEND_FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vldb_q <= 1'b0;
    else if (en_i) vldb_q <= vlda_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      postb_q <= posta_q;
      ato_b_q <= ato_b_d;
      afr_b_q <= tha_q - ato_b_d;
    end
  end

  // rotation lanes: 0 is the from weight, 1 the to weight
  logic                    vld_q  [ANG_STEPS+1];
  post_t                   post_q [ANG_STEPS+1];
  logic signed [SIN_W-1:0] x_q    [ANG_STEPS+1][2];
  logic signed [SIN_W-1:0] y_q    [ANG_STEPS+1][2];
  logic signed [ANG_W-1:0] a_q    [ANG_STEPS+1][2];

  logic signed [ANG_W-1:0] afr_w, ato_w, a0_d [2];

  // angles above pi/2 fold to pi - angle
  always_comb begin
    afr_w   = $signed(ANG_W'(afr_b_q));
    ato_w   = $signed(ANG_W'(ato_b_q));
    a0_d[0] = (afr_w > HALF_PI_Q16) ? PI_Q16 - afr_w : afr_w;
    a0_d[1] = (ato_w > HALF_PI_Q16) ? PI_Q16 - ato_w : ato_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= vldb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      post_q[0] <= postb_q;
      for (int l = 0; l < 2; l++) begin
        x_q[0][l] <= INV_GAIN_Q30;
        y_q[0][l] <= '0;
        a_q[0][l] <= a0_d[l];
      end
    end
  end

  for (genvar k = 0; k < ANG_STEPS; k++) begin : g_rot
    logic signed [SIN_W-1:0] x_d [2];
    logic signed [SIN_W-1:0] y_d [2];
    logic signed [ANG_W-1:0] a_d [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (a_q[k][l] >= 0) begin
          x_d[l] = x_q[k][l] - (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] + (x_q[k][l] >>> k);
          a_d[l] = a_q[k][l] - ATAN_Q16[k];
        end else begin
          x_d[l] = x_q[k][l] + (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] - (x_q[k][l] >>> k);
          a_d[l] = a_q[k][l] + ATAN_Q16[k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        post_q[k+1] <= post_q[k];
        x_q[k+1]    <= x_d;
        y_q[k+1]    <= y_d;
        a_q[k+1]    <= a_d;
      end
    end
  end

  assign vld_o    = vld_q[ANG_STEPS];
  assign post_o   = post_q[ANG_STEPS];
  assign w_from_o = y_q[ANG_STEPS][0];
  assign w_to_o   = y_q[ANG_STEPS][1];

endmodule

FILE: design/qslerp_div.sv
// numerators and pipelined restoring division by sin(theta), four lanes
`timescale 1ns / 1ps
module qslerp_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  qslerp_pkg::post_t                    post_i,
  input  logic signed [qslerp_pkg::SIN_W-1:0]  w_from_i,
  input  logic signed [qslerp_pkg::SIN_W-1:0]  w_to_i,
  output logic                                 vld_o,
  output qslerp_pkg::post_t                    post_o,
  output qslerp_pkg::lane_t [3:0]              lane_o
);
  import qslerp_pkg::*;

  localparam int PRD_W = SIN_W + COMP_W;

  // stage 1: weight products
  logic                    vld1_q;
  post_t                   post1_q;
  logic signed [PRD_W-1:0] pf1_q [4];
  logic signed [PRD_W-1:0] pg1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (en_i) vld1_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      post1_q <= post_i;
      for (int i = 0; i < 4; i++) begin
        pf1_q[i] <= PRD_W'(w_from_i) * PRD_W'($signed(post_i.side.f[i]));
        pg1_q[i] <= PRD_W'(w_to_i) * PRD_W'($signed(post_i.side.g[i]));
      end
    end
  end

  // stage 2: numerator sign and magnitude
  logic                    vld2_q;
  post_t                   post2_q;
  logic [NUM_W-1:0]        mag2_q [4];
  logic                    neg2_q [4];
  logic                    zero2_q [4];
  logic signed [NUM_W-1:0] num [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = NUM_W'(pf1_q[i]) + NUM_W'(pg1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld2_q <= 1'b0;
    else if (en_i) vld2_q <= vld1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      post2_q <= post1_q;
      for (int i = 0; i < 4; i++) begin
        mag2_q[i]  <= (num[i] < 0) ? NUM_W'(-num[i]) : NUM_W'(num[i]);
        neg2_q[i]  <= (num[i] < 0);
        zero2_q[i] <= (num[i] == '0);
      end
    end
  end

  // stage 3: range check, a quotient past the component range clips
  logic             vld_q  [QUOT_BITS+1];
  post_t            post_q [QUOT_BITS+1];
  lane_t            ln_q   [QUOT_BITS+1][4];
  logic [REM_W-1:0] rem_q  [QUOT_BITS+1][4];

  lane_t            ln0_d [4];
  logic [NUM_W-1:0] lim [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lim[i] = (NUM_W'(post2_q.s) << (QUOT_BITS - 1))
               + (neg2_q[i] ? NUM_W'(post2_q.s) : '0);
      ln0_d[i].neg  = neg2_q[i];
      ln0_d[i].zero = zero2_q[i];
      ln0_d[i].sat  = (mag2_q[i] >= lim[i]);
      ln0_d[i].q    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= vld2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      post_q[0] <= post2_q;
      for (int i = 0; i < 4; i++) begin
        ln_q[0][i]  <= ln0_d[i];
        rem_q[0][i] <= REM_W'(mag2_q[i]);
      end
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_quot
    localparam int SH = QUOT_BITS - 1 - j;
    logic [REM_W-1:0] den;
    logic [REM_W-1:0] rem_d [4];
    lane_t            ln_d  [4];

    assign den = REM_W'(REM_W'(post_q[j].s) << SH);

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        ln_d[i] = ln_q[j][i];
        if (rem_q[j][i] >= den) begin
          rem_d[i]     = rem_q[j][i] - den;
          ln_d[i].q[SH] = 1'b1;
        end else begin
          rem_d[i] = rem_q[j][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[j+1] <= 1'b0;
      else if (en_i) vld_q[j+1] <= vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        post_q[j+1] <= post_q[j];
        ln_q[j+1]   <= ln_d;
        rem_q[j+1]  <= rem_d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_o[i] = ln_q[QUOT_BITS][i];
    end
  end

  assign vld_o  = vld_q[QUOT_BITS];
  assign post_o = post_q[QUOT_BITS];

endmodule

FILE: tb/qslerp_tb_if.sv
// result type shared by the slerp testbench
`timescale 1ns / 1ps
package qslerp_tb_types_pkg;
  import qslerp_pkg::*;
  typedef struct packed {
    logic signed [COMP_W-1:0] w, x, y, z;
    logic                     sat;
  } slerp_res_t;
endpackage

FILE: tb/quaternion_slerp_core_test.sv
// testbench for the quaternion slerp core: random and corner beats checked against a predictor
`timescale 1ns / 1ps
module quaternion_slerp_core_test;
  import qslerp_pkg::*;
  import qslerp_tb_types_pkg::*;

  typedef struct packed {
    logic signed [COMP_W-1:0] fw, fx, fy, fz, gw, gx, gy, gz;
    logic [BLEND_W-1:0]       t;
  } slerp_req_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  qslerp_in_if  in_ch ();
  qslerp_out_if out_ch ();

  quaternion_slerp_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  slerp_req_t pending_q[$];
  slerp_res_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 17;
  int recv_idle_pct = 65;
  bit hold_send = 1'b0;
  int quiet_cycles = 0;

  localparam longint ATAN_TBL [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2, 1};

  function automatic longint isqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint cordic_sine(longint a);
    longint x, y, xs, ys;
    x = 652032874;
    y = 0;
    if (a > 102944) a = 205887 - a;
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= ATAN_TBL[i];
      end else begin
        x += ys; y -= xs; a += ATAN_TBL[i];
      end
    end
    return y;
  endfunction

  function automatic longint clip_comp(longint v, ref bit flag);
    if (v > 32767) begin
      flag = 1; return 32767;
    end
    if (v < -32768) begin
      flag = 1; return -32768;
    end
    return v;
  endfunction

  function automatic slerp_res_t predict_slerp(slerp_req_t q);
    longint f[4], g[4], r[4];
    longint dot, d30, s, theta, t, a_to, w_from, w_to, n;
    longint unsigned m;
    bit flag, same;
    slerp_res_t res;
    f = '{q.fw, q.fx, q.fy, q.fz};
    g = '{q.gw, q.gx, q.gy, q.gz};
    dot = 0;
    flag = 0;
    same = 1;
    for (int i = 0; i < 4; i++) begin
      if (f[i] != g[i]) same = 0;
      dot += f[i] * g[i];
    end
    t = (q.t > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(q.t);
    if (same) begin
      r = f;
    end else begin
      if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
      if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
      if (dot == (64'sd1 << 28)) begin
        for (int i = 0; i < 4; i++)
          r[i] = clip_comp(f[i] + (((g[i] - f[i]) * t) >>> 16), flag);
      end else begin
        d30 = dot <<< 2;
        m = (d30 < 0) ? -d30 : d30;
        s = isqrt_floor((64'd1 << 60) - m * m);
        if (d30 >= 0) theta = cordic_angle(d30, s);
        else theta = 102944 + cordic_angle(s, -d30);
        if (theta < 0) theta = 0;
        if (theta > 205887) theta = 205887;
        a_to = (theta * t) >>> 16;
        w_from = cordic_sine(theta - a_to);
        w_to = cordic_sine(a_to);
        for (int i = 0; i < 4; i++) begin
          n = w_from * f[i] + w_to * g[i];
          if (s == 0) begin
            flag = 1;
            r[i] = (n > 0) ? 32767 : ((n < 0) ? -32768 : 0);
          end else begin
            r[i] = clip_comp(n / s, flag);
          end
        end
      end
    end
    res.w = r[0][15:0];
    res.x = r[1][15:0];
    res.y = r[2][15:0];
    res.z = r[3][15:0];
    res.sat = flag;
    return res;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16384));
      2: return -16'($urandom_range(0, 16384));
      3: return 16'($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 16000)) - 8000);
    endcase
  endfunction

  function automatic logic [BLEND_W-1:0] rand_blend();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 1)) ? BLEND_ONE : '0;
      1: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic add_beat(logic [15:0] fw, fx, fy, fz, gw, gx, gy, gz,
                          logic [BLEND_W-1:0] t);
    slerp_req_t q;
    q = '{fw, fx, fy, fz, gw, gx, gy, gz, t};
    pending_q.push_back(q);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.from_w, in_ch.from_x, in_ch.from_y, in_ch.from_z} <= '0;
      {in_ch.to_w, in_ch.to_x, in_ch.to_y, in_ch.to_z} <= '0;
      in_ch.blend <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_q.push_back(predict_slerp(
          '{in_ch.from_w, in_ch.from_x, in_ch.from_y, in_ch.from_z,
            in_ch.to_w, in_ch.to_x, in_ch.to_y, in_ch.to_z, in_ch.blend}));
      if (pending_q.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        slerp_req_t q;
        q = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.from_w, in_ch.from_x, in_ch.from_y, in_ch.from_z} <= {q.fw, q.fx, q.fy, q.fz};
        {in_ch.to_w, in_ch.to_x, in_ch.to_y, in_ch.to_z} <= {q.gw, q.gx, q.gy, q.gz};
        in_ch.blend <= q.t;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      quiet_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                      ? 0 : quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        slerp_res_t got, want;
        got = '{out_ch.out_w, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.saturated};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat got %p", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z || got.sat !== want.sat) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quaternion_slerp_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // equal inputs, extremes, dot of one, antiparallel, blend beyond one
    add_beat(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 17'h08000);
    add_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
             16'h8000, 17'h1ffff);
    add_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 17'h0);
    add_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 17'h08000);
    add_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 17'h10000);
    add_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 17'h1ffff);
    add_beat(16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 17'h08000);
    add_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 17'h04000);
    add_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
             16'h7ffe, 17'h0c000);
    add_beat(16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000,
             16'h2001, 17'h10000);
    add_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h4000, 0, 0, 0, 17'h00001);
    add_beat(16'h2d41, 16'h2d41, 0, 0, 16'h2d41, 0, 16'h2d41, 0, 17'h0ffff);
    add_beat(0, 0, 0, 0, 16'h4000, 0, 0, 0, 17'h08000);
    add_beat(16'h4000, 0, 0, 0, 16'h3fff, 16'h0100, 0, 0, 17'h08000);
    for (int i = 0; i < 850; i++) begin
      if (i == 280 || i == 420 || i == 560) begin
        // the queued beats go out under the current idle pattern first
        wait (pending_q.size() == 0);
      end
      if (i == 280) begin
        send_idle_pct = 65;
        recv_idle_pct = 17;
      end
      if (i == 560) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 420) begin
        // let the pipe drain completely before going on
        wait (pending_q.size() == 0);
        hold_send = 1'b1;
        wait (expected_q.size() == 0 && !in_ch.valid);
        hold_send = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        logic [15:0] a, b, c, d;
        a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
        add_beat(a, b, c, d, ($urandom_range(0, 1)) ? a : a + 16'($urandom_range(0, 3)),
                 b, c, d, rand_blend());
      end else begin
        add_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_blend());
      end
    end
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!in_ch.valid && expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("quaternion_slerp_core_test OK");
    end else begin
      $display("quaternion_slerp_core_test NOT OK");
    end
    $finish;
  end
endmodule
